// ===== hw/rtl/euler_to_rotation_matrix_macros.svh =====
// Assertion macros used by the top level of the Euler-angle to rotation-matrix block
`ifndef EULER_TO_ROTATION_MATRIX_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define E2R_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define E2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/e2r_pkg.sv =====
// Package with constants, arctangent table and helpers for the rotation-matrix block
`timescale 1ns / 1ps
`default_nettype none
package e2r_pkg;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int OUT_WIDTH_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 14;
    // Q30 datapath plus sign and growth headroom
    localparam int QW    = 34;
    localparam int PW    = 2 * QW;
    localparam int FRAC  = 30;
    localparam logic signed [QW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [QW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef logic signed [QW-1:0] q30_t;

    typedef struct packed {
        logic valid;
        logic view;
    } e2r_ctl_t;

    function automatic q30_t atan_q30(input int i);
        q30_t r;
        r = '0;
        unique case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            default: r = (i < 30) ? (q30_t'(1) <<< (30 - i)) : '0;
        endcase
        return r;
    endfunction

    // Elaboration-time root of the gain: isqrt(prod(1 + 2^-2i)) in Q30
    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_v;
        longint unsigned vv;
        res = 0;
        vv = v;
        bit_v = 64'd1 << 62;
        while (bit_v > vv) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (vv >= res + bit_v) begin
                vv = vv - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned cordic_root(input int steps);
        longint unsigned g;
        longint unsigned s;
        g = 64'd1 << 60;
        for (int i = 0; i < steps && i < 30; i++) g = g + (g >> (2 * i));
        s = isqrt64(g);
        if (s == 0) s = 1;
        return s;
    endfunction

    // Q30 product floored back to Q30
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [PW-1:0] p;
        p = a * b;
        return q30_t'(p >>> FRAC);
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/euler_to_rotation_matrix.sv =====
// Top level: Euler angles to 3x3 rotation-matrix entries
// Channel | Direction | Handshake       | Payload
// in      | sink      | in_valid/stall  | heading, pitch, roll
// out     | source    | out_valid/stall | m00..m22
// cfg     | sink      | valid/ready     | view_layout
// One item per cycle through three CORDIC lanes while the output is not stalled.
// The whole pipeline advances as one while the output register is free or taken.
// A stall on a valid output freezes every stage, so the input is stalled too.
// Reset clears the valid pipeline and the layout register.
`timescale 1ns / 1ps
`default_nettype none
`include "euler_to_rotation_matrix_macros.svh"
module euler_to_rotation_matrix #(
    parameter int ANGLE_WIDTH  = e2r_pkg::ANGLE_WIDTH_DEF,
    parameter int OUT_WIDTH    = e2r_pkg::OUT_WIDTH_DEF,
    parameter int CORDIC_STEPS = e2r_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [ANGLE_WIDTH-1:0] heading,
    input  wire logic signed [ANGLE_WIDTH-1:0] pitch,
    input  wire logic signed [ANGLE_WIDTH-1:0] roll,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [OUT_WIDTH-1:0]        m00,
    output logic signed [OUT_WIDTH-1:0]        m01,
    output logic signed [OUT_WIDTH-1:0]        m02,
    output logic signed [OUT_WIDTH-1:0]        m10,
    output logic signed [OUT_WIDTH-1:0]        m11,
    output logic signed [OUT_WIDTH-1:0]        m12,
    output logic signed [OUT_WIDTH-1:0]        m20,
    output logic signed [OUT_WIDTH-1:0]        m21,
    output logic signed [OUT_WIDTH-1:0]        m22,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_data
);
    import e2r_pkg::*;
    // fold stage, CORDIC stages, product stage, cross-product stage
    localparam int DEPTH = CORDIC_STEPS + 3;

    logic view_reg;
    logic [DEPTH-1:0] vld_reg;
    logic en;
    q30_t sh, ch, sp, cp, sr, cr;
    logic [OUT_WIDTH-1:0] mm [9];

    assign cfg_ready = 1'b1;
    // advance when the last stage is empty or being taken
    assign en = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid) view_reg <= cfg_data;
            if (en) vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    e2r_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_h
        (.clk(clk), .en(en), .angle(heading), .sin_q(sh), .cos_q(ch));
    e2r_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_p
        (.clk(clk), .en(en), .angle(pitch), .sin_q(sp), .cos_q(cp));
    e2r_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_r
        (.clk(clk), .en(en), .angle(roll), .sin_q(sr), .cos_q(cr));

    e2r_merge #(.OUT_WIDTH(OUT_WIDTH)) u_merge
        (.clk(clk), .en(en), .view(view_reg), .sh(sh), .ch(ch), .sp(sp), .cp(cp),
         .sr(sr), .cr(cr), .m(mm));

    assign m00 = mm[0];
    assign m01 = mm[1];
    assign m02 = mm[2];
    assign m10 = mm[3];
    assign m11 = mm[4];
    assign m12 = mm[5];
    assign m20 = mm[6];
    assign m21 = mm[7];
    assign m22 = mm[8];

    `E2R_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall)
    `E2R_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall, out_valid)
    `E2R_ASSERT_NEXT(a_accept_moves, clk, rst_n, in_valid && !in_stall, vld_reg[0])
endmodule
`default_nettype wire

// ===== hw/rtl/e2r_cordic_lane.sv =====
// One pipelined rotation-mode CORDIC lane giving sine and cosine in Q30
`timescale 1ns / 1ps
`default_nettype none
module e2r_cordic_lane #(
    parameter int ANGLE_WIDTH  = e2r_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = e2r_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [ANGLE_WIDTH-1:0] angle,
    output e2r_pkg::q30_t                      sin_q,
    output e2r_pkg::q30_t                      cos_q
);
    import e2r_pkg::*;
    localparam longint unsigned ROOT = cordic_root(CORDIC_STEPS);
    // inverse gain, rounded: 2^60 / root
    localparam q30_t K = q30_t'(((64'd1 << 60) + (ROOT >> 1)) / ROOT);
    localparam int UP = 30 - (ANGLE_WIDTH - 3);

    q30_t x_reg [CORDIC_STEPS+1];
    q30_t y_reg [CORDIC_STEPS+1];
    q30_t z_reg [CORDIC_STEPS+1];
    logic flip_reg [CORDIC_STEPS+1];
    q30_t z_in;
    q30_t z_fold;
    logic flip_in;

    always_comb
    begin
        z_in = q30_t'(angle) <<< UP;
        z_fold = z_in;
        flip_in = 1'b0;
        if (z_in > HALF_PI_Q30)
        begin
            z_fold = z_in - PI_Q30;
            flip_in = 1'b1;
        end
        else if (z_in < -HALF_PI_Q30)
        begin
            z_fold = z_in + PI_Q30;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= K;
            y_reg[0] <= '0;
            z_reg[0] <= z_fold;
            flip_reg[0] <= flip_in;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][QW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    assign sin_q = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    assign cos_q = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
endmodule
`default_nettype wire

// ===== hw/rtl/e2r_merge.sv =====
// Merging stages: products, cross product, rounding, saturation and layout
`timescale 1ns / 1ps
`default_nettype none
module e2r_merge #(
    parameter int OUT_WIDTH = e2r_pkg::OUT_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          view,
    input  wire e2r_pkg::q30_t sh,
    input  wire e2r_pkg::q30_t ch,
    input  wire e2r_pkg::q30_t sp,
    input  wire e2r_pkg::q30_t cp,
    input  wire e2r_pkg::q30_t sr,
    input  wire e2r_pkg::q30_t cr,
    output logic [OUT_WIDTH-1:0] m [9]
);
    import e2r_pkg::*;
    localparam int OFR = OUT_WIDTH - 2;
    localparam int SH = 30 - OFR;

    q30_t a_reg [6];   // m00 m01 m02 m10 m11 m12
    q30_t p_reg [6];   // cross-product terms
    q30_t e_reg [6];
    logic v1_reg, v2_reg;

    function automatic logic [OUT_WIDTH-1:0] to_out(input q30_t v);
        q30_t r;
        q30_t lim;
        lim = q30_t'(1) <<< OFR;
        if (SH > 0) r = (v + (q30_t'(1) <<< (SH - 1))) >>> SH;
        else r = v;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[OUT_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= mulq(cr, ch);
            a_reg[1] <= -mulq(cr, sh);
            a_reg[2] <= -sr;
            a_reg[3] <= mulq(cp, sh);
            a_reg[4] <= mulq(cp, ch);
            a_reg[5] <= sp;
            v1_reg <= view;
            p_reg[0] <= mulq(a_reg[1], a_reg[5]);
            p_reg[1] <= mulq(a_reg[2], a_reg[4]);
            p_reg[2] <= mulq(a_reg[2], a_reg[3]);
            p_reg[3] <= mulq(a_reg[0], a_reg[5]);
            p_reg[4] <= mulq(a_reg[0], a_reg[4]);
            p_reg[5] <= mulq(a_reg[1], a_reg[3]);
            for (int i = 0; i < 6; i++) e_reg[i] <= a_reg[i];
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        q30_t f [9];
        for (int i = 0; i < 6; i++) f[i] = e_reg[i];
        f[6] = p_reg[0] - p_reg[1];
        f[7] = p_reg[2] - p_reg[3];
        f[8] = p_reg[4] - p_reg[5];
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r*3+c] = to_out(v2_reg ? f[c*3+r] : f[r*3+c]);
    end
endmodule
`default_nettype wire

// ===== tb/euler_to_rotation_matrix_checker.sv =====
// Checker: predicts the matrix entries of each accepted angle triple and compares the results
`timescale 1ns / 1ps
module euler_to_rotation_matrix_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] heading,
    input  logic [15:0] pitch,
    input  logic [15:0] roll,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] m00,
    input  logic [15:0] m01,
    input  logic [15:0] m02,
    input  logic [15:0] m10,
    input  logic [15:0] m11,
    input  logic [15:0] m12,
    input  logic [15:0] m20,
    input  logic [15:0] m21,
    input  logic [15:0] m22,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          fail_count,
    output int          pending,
    output int          matrices_checked
);
    localparam int STEPS = e2r_pkg::CORDIC_STEPS_DEF;
    localparam longint PI_FX = 64'sd3373259426;
    localparam longint HALF_PI_FX = 64'sd1686629713;

    typedef logic [8:0][15:0] matrix_t;

    localparam longint ATAN_FX [0:13] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072
    };

    matrix_t matrix_queue[$];
    logic    view_q;
    longint  gain_inv;

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint inverse_gain();
        longint unsigned g;
        longint unsigned s;
        g = 64'd1 << 60;
        for (int i = 0; i < STEPS; i++) g = g + (g >> (2 * i));
        s = root64(g);
        if (s == 0) s = 1;
        return longint'(((64'd1 << 60) + (s >> 1)) / s);
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        x = gain_inv;
        y = 0;
        z = ang;
        flip = 0;
        // fold into [-pi/2, pi/2], negating both outputs
        if (z > HALF_PI_FX)
        begin
            z = z - PI_FX;
            flip = 1;
        end
        else if (z < -HALF_PI_FX)
        begin
            z = z + PI_FX;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_FX[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_FX[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic [15:0] round_sat(input longint v);
        longint r;
        r = (v + (64'sd1 << 15)) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    task automatic predict_matrix(input logic [15:0] h, input logic [15:0] p,
                                  input logic [15:0] r, input logic view,
                                  output matrix_t res);
        longint sh, ch, sp, cp, sr, cr;
        longint m [3][3];
        sin_cos(longint'($signed(h)) <<< 17, sh, ch);
        sin_cos(longint'($signed(p)) <<< 17, sp, cp);
        sin_cos(longint'($signed(r)) <<< 17, sr, cr);
        m[0][0] = fx_mul(cr, ch);
        m[0][1] = -fx_mul(cr, sh);
        m[0][2] = -sr;
        m[1][0] = fx_mul(cp, sh);
        m[1][1] = fx_mul(cp, ch);
        m[1][2] = sp;
        m[2][0] = fx_mul(m[0][1], m[1][2]) - fx_mul(m[0][2], m[1][1]);
        m[2][1] = fx_mul(m[0][2], m[1][0]) - fx_mul(m[0][0], m[1][2]);
        m[2][2] = fx_mul(m[0][0], m[1][1]) - fx_mul(m[0][1], m[1][0]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                res[i * 3 + j] = round_sat(view ? m[j][i] : m[i][j]);
    endtask

    initial
    begin
        gain_inv = inverse_gain();
        fail_count = 0;
        matrices_checked = 0;
    end

    assign pending = matrix_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        matrix_t want;
        matrix_t got;
        if (!rst_n)
            view_q <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
                view_q <= cfg_data;
            if (in_valid && !in_stall)
            begin
                predict_matrix(heading, pitch, roll, view_q, want);
                matrix_queue.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
                if (matrix_queue.size() == 0)
                begin
                    $display("%0t: unexpected matrix transaction", $time);
                    fail_count++;
                end
                else
                begin
                    want = matrix_queue.pop_front();
                    matrices_checked++;
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== want[i])
                        begin
                            $display("%0t: m%0d%0d expected %0d actual %0d", $time,
                                     i / 3, i % 3, $signed(want[i]), $signed(got[i]));
                            fail_count++;
                        end
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the regression: clock, reset, stimulus and verdict for the rotation-matrix block
`timescale 1ns / 1ps
module testbench;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] heading, pitch, roll;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    int          fail_count, pending, matrices_checked;

    bit quiet_out;   // receiver never stalls
    bit hold_req;    // receiver holds off for a long stretch

    localparam logic [15:0] EDGES [0:9] = '{
        16'h8000, 16'h7fff, 16'h0000, 16'd12867, 16'd12868,
        -16'sd12867, -16'sd12868, 16'd25736, -16'sd25736, 16'hffff
    };

    euler_to_rotation_matrix u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .heading(heading), .pitch(pitch), .roll(roll),
        .out_valid(out_valid), .out_stall(out_stall),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
        .m12(m12), .m20(m20), .m21(m21), .m22(m22),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    euler_to_rotation_matrix_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .heading(heading), .pitch(pitch), .roll(roll),
        .out_valid(out_valid), .out_stall(out_stall),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
        .m12(m12), .m20(m20), .m21(m21), .m22(m22),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .matrices_checked(matrices_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int short_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 16'($urandom);
        if (pick < 8) return 16'($signed($urandom_range(12860, 12876)) *
                                 ($urandom_range(0, 1) ? 1 : -1));
        return 16'($signed($urandom_range(0, 64)) - 32);
    endfunction

    task automatic send_angles(input logic [15:0] h, input logic [15:0] p,
                               input logic [15:0] r);
        heading <= h;
        pitch <= p;
        roll <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // called at a falling edge right after a transaction
    task automatic idle_sender(input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (25) @(negedge clk);
    endtask

    task automatic write_view(input logic v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed(input bit gaps);
        for (int i = 0; i < 10; i++)
        begin
            send_angles(EDGES[i], EDGES[(i + 3) % 10], EDGES[(i + 7) % 10]);
            idle_sender(gaps ? short_gap() : 0);
        end
        send_angles(16'd6434, -16'sd6434, 16'd4289);
        idle_sender(0);
        send_angles(16'd12868, 16'd12868, 16'd12868);
        idle_sender(0);
    endtask

    task automatic run_random(input int count, input bit gaps);
        for (int i = 0; i < count; i++)
        begin
            send_angles(rand_angle(), rand_angle(), rand_angle());
            idle_sender(gaps ? short_gap() : 0);
        end
    endtask

    // receiver side
    initial
    begin
        int len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (150) @(negedge clk);
                hold_req = 0;
                out_stall <= 1'b0;
            end
            else if (!quiet_out)
            begin
                len = short_gap();
                if (len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (len) @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("euler_to_rotation_matrix regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        heading = '0;
        pitch = '0;
        roll = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        quiet_out = 1;
        hold_req = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset layout, back to back, then transposed layout with gaps
        run_directed(0);
        drain();
        write_view(1'b1);
        quiet_out = 0;
        run_directed(1);
        drain();

        write_view(1'b0);
        run_random(500, 1);
        // pause until every matrix is back
        drain();
        run_random(100, 1);
        drain();

        write_view(1'b1);
        quiet_out = 1;
        run_random(300, 0);
        // long hold-off while the sender keeps offering
        quiet_out = 0;
        hold_req = 1;
        run_random(200, 0);
        run_random(300, 1);
        drain();

        write_view(1'b0);
        run_random(300, 1);
        drain();
        write_view(1'b1);
        run_random(300, 1);
        drain();

        $display("covered both layouts, angle extremes and fold boundaries, %0d matrices checked",
                 matrices_checked);
        $display("with random gaps, back-to-back runs, a long output hold-off and full drains");
        if (fail_count == 0)
            $display("euler_to_rotation_matrix regression: pass");
        else
            $display("euler_to_rotation_matrix regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/e2r_pkg.sv
hw/rtl/e2r_cordic_lane.sv
hw/rtl/e2r_merge.sv
hw/rtl/euler_to_rotation_matrix.sv
tb/euler_to_rotation_matrix_checker.sv
tb/testbench.sv
